FILE: rtl/core/dh_link_transform_unit_defines.svh
// Assertion macros for the DH link transform unit.
// No dependencies.
`ifndef DH_LINK_TRANSFORM_UNIT_DEFINES_SVH
`define DH_LINK_TRANSFORM_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define DH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/dhlt_pkg.sv
// Shared types and constants for the DH link transform unit.
// No dependencies.
package dhlt_pkg;
    localparam int CORDIC_ITERS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [23:0] LEN_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] LEN_MIN = -24'sh800000;

    typedef logic signed [33:0] t_cw;

    function automatic logic signed [33:0] atan_lut(input int i);
        logic signed [33:0] v;
        case (i)
            0: v = 34'sd536870912;  1: v = 34'sd316933406;
            2: v = 34'sd167458907;  3: v = 34'sd85004756;
            4: v = 34'sd42667331;   5: v = 34'sd21354465;
            6: v = 34'sd10679838;   7: v = 34'sd5340245;
            8: v = 34'sd2670163;    9: v = 34'sd1335087;
            10: v = 34'sd667544;    11: v = 34'sd333772;
            12: v = 34'sd166886;    13: v = 34'sd83443;
            14: v = 34'sd41722;     15: v = 34'sd20861;
            16: v = 34'sd10430;     17: v = 34'sd5215;
            18: v = 34'sd2608;      19: v = 34'sd1304;
            20: v = 34'sd652;       21: v = 34'sd326;
            22: v = 34'sd163;       23: v = 34'sd81;
            24: v = 34'sd41;        25: v = 34'sd20;
            26: v = 34'sd10;        27: v = 34'sd5;
            28: v = 34'sd3;         29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

FILE: rtl/core/dhlt_cordic.sv
// Pipelined sine/cosine: quadrant reduction, 30 CORDIC stages, rounding.
// Depends on dhlt_pkg.
module dhlt_cordic #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output logic signed [17:0]    o_cos,
    output logic signed [17:0]    o_sin
);
    import dhlt_pkg::*;
    localparam int N = CORDIC_ITERS;
    localparam int SH = 30 - TRIG_FRAC_BITS;

    logic [31:0] w_p, w_diff;
    logic [1:0]  w_q;
    t_cw r_x [N+1];
    t_cw r_y [N+1];
    t_cw r_z [N+1];
    logic [1:0] r_q [N+1];
    logic signed [17:0] r_cos, r_sin;

    assign w_p = {i_angle, {(32-ANGLE_BITS){1'b0}}};
    assign w_q = 2'((w_p + 32'h2000_0000) >> 30);
    assign w_diff = w_p - {w_q, 30'd0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= t_cw'(signed'(w_diff));
        r_q[0] <= w_q;
    end

    // One rotation per stage.
    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_q[i+1] <= r_q[i];
            if (!r_z[i][33]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_lut(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_lut(i);
            end
        end
    end

    function automatic logic signed [17:0] rnd(input t_cw v);
        t_cw t;
        t = (v + (t_cw'(1) <<< (SH - 1))) >>> SH;
        if (t > (t_cw'(1) <<< TRIG_FRAC_BITS)) t = t_cw'(1) <<< TRIG_FRAC_BITS;
        if (t < -(t_cw'(1) <<< TRIG_FRAC_BITS)) t = -(t_cw'(1) <<< TRIG_FRAC_BITS);
        return t[17:0];
    endfunction

    t_cw w_c, w_s;
    always_comb begin
        case (r_q[N])
            2'd0: begin w_c = r_x[N];  w_s = r_y[N];  end
            2'd1: begin w_c = -r_y[N]; w_s = r_x[N];  end
            2'd2: begin w_c = -r_x[N]; w_s = -r_y[N]; end
            default: begin w_c = r_y[N]; w_s = -r_x[N]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cos <= rnd(w_c);
        r_sin <= rnd(w_s);
    end
    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

FILE: rtl/core/dhlt_mul.sv
// Product stage: one registered multiply, then rounding and clamping.
// Depends on dhlt_pkg.
module dhlt_mul #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic signed [17:0] i_ct,
    input  logic signed [17:0] i_st,
    input  logic signed [17:0] i_ca,
    input  logic signed [17:0] i_sa,
    input  logic signed [23:0] i_len,
    output logic signed [17:0] o_sc_neg,
    output logic signed [17:0] o_ss,
    output logic signed [17:0] o_cc,
    output logic signed [17:0] o_cs_neg,
    output logic signed [23:0] o_lc,
    output logic signed [23:0] o_ls
);
    import dhlt_pkg::*;
    localparam int F = TRIG_FRAC_BITS;
    logic signed [35:0] r_sc, r_ss, r_cc, r_cs;
    logic signed [41:0] r_lc, r_ls;

    always_ff @(posedge i_clk) begin
        r_sc <= i_st * i_ca;
        r_ss <= i_st * i_sa;
        r_cc <= i_ct * i_ca;
        r_cs <= i_ct * i_sa;
        r_lc <= i_len * i_ct;
        r_ls <= i_len * i_st;
    end

    function automatic logic signed [17:0] trnd(input logic signed [35:0] v);
        logic signed [36:0] t;
        t = (37'(v) + (37'sd1 <<< (F - 1))) >>> F;
        if (t > (37'sd1 <<< F)) t = 37'sd1 <<< F;
        if (t < -(37'sd1 <<< F)) t = -(37'sd1 <<< F);
        return t[17:0];
    endfunction

    function automatic logic signed [23:0] lrnd(input logic signed [41:0] v);
        logic signed [42:0] t;
        t = (43'(v) + (43'sd1 <<< (F - 1))) >>> F;
        if (t > 43'(LEN_MAX)) t = 43'(LEN_MAX);
        if (t < 43'(LEN_MIN)) t = 43'(LEN_MIN);
        return t[23:0];
    endfunction

    always_ff @(posedge i_clk) begin
        o_sc_neg <= -trnd(r_sc);
        o_ss     <= trnd(r_ss);
        o_cc     <= trnd(r_cc);
        o_cs_neg <= -trnd(r_cs);
        o_lc     <= lrnd(r_lc);
        o_ls     <= lrnd(r_ls);
    end
endmodule

FILE: rtl/core/dh_link_transform_unit.sv
// DH link transform unit: top level.
// Depends on dhlt_pkg, dhlt_cordic, dhlt_mul and the defines header.
//
// Usage: raise start with joint angle, twist angle, link length and
// link offset on the input ports; the word is taken at the clock edge
// where start is high (busy is always low, so every cycle can take
// a new word). Two pipelined CORDIC units (32 stages: load, 30
// rotations, quadrant fixup and rounding) give cos/sin of both angles,
// then a two-stage multiply block forms the products; throughput is
// one word per cycle.
// o_valid is high for exactly one cycle per word with all eleven
// matrix entries; the receiver cannot stall, so results are never held.
// Length and offset are delayed alongside the trig pipe in shift lines.
// Reset (synchronous, i_rst_n low) clears only the valid shift line;
// data registers carry no reset. Words in flight at reset are dropped.
`include "dh_link_transform_unit_defines.svh"
module dh_link_transform_unit #(
    parameter int ANGLE_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_joint_angle,
    input  logic [15:0]        i_twist_angle,
    input  logic signed [23:0] i_link_length,
    input  logic signed [23:0] i_link_offset,
    output logic               o_valid,
    output logic signed [17:0] o_m00_cos_theta,
    output logic signed [17:0] o_m01_neg_sin_cos,
    output logic signed [17:0] o_m02_sin_sin,
    output logic signed [23:0] o_m03_len_cos,
    output logic signed [17:0] o_m10_sin_theta,
    output logic signed [17:0] o_m11_cos_cos,
    output logic signed [17:0] o_m12_neg_cos_sin,
    output logic signed [23:0] o_m13_len_sin,
    output logic signed [17:0] o_m21_sin_alpha,
    output logic signed [17:0] o_m22_cos_alpha,
    output logic signed [23:0] o_m23_offset
);
    import dhlt_pkg::*;
    localparam int TRIG_LAT = CORDIC_ITERS + 2;
    localparam int LAT = TRIG_LAT + 2;

    logic signed [17:0] w_ct, w_st, w_ca, w_sa;
    logic [LAT-1:0] r_vld;
    logic signed [23:0] r_len [TRIG_LAT];
    logic signed [23:0] r_off [LAT];
    logic signed [17:0] r_ct [2];
    logic signed [17:0] r_st [2];
    logic signed [17:0] r_ca [2];
    logic signed [17:0] r_sa [2];

    assign busy = 1'b0;

    dhlt_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_theta (
        .i_clk(i_clk), .i_angle(i_joint_angle[ANGLE_BITS-1:0]),
        .o_cos(w_ct), .o_sin(w_st));
    dhlt_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_alpha (
        .i_clk(i_clk), .i_angle(i_twist_angle[ANGLE_BITS-1:0]),
        .o_cos(w_ca), .o_sin(w_sa));

    dhlt_mul #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_ct(w_ct), .i_st(w_st), .i_ca(w_ca), .i_sa(w_sa),
        .i_len(r_len[TRIG_LAT-1]),
        .o_sc_neg(o_m01_neg_sin_cos), .o_ss(o_m02_sin_sin),
        .o_cc(o_m11_cos_cos), .o_cs_neg(o_m12_neg_cos_sin),
        .o_lc(o_m03_len_cos), .o_ls(o_m13_len_sin));

    // Advance the valid line every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-2:0], start & ~busy};
    end

    // Delay lines for payload that bypasses the trig units or the multiply block.
    always_ff @(posedge i_clk) begin
        r_len[0] <= i_link_length;
        for (int k = 1; k < TRIG_LAT; k++) r_len[k] <= r_len[k-1];
        r_off[0] <= i_link_offset;
        for (int k = 1; k < LAT; k++) r_off[k] <= r_off[k-1];
        r_ct[0] <= w_ct; r_ct[1] <= r_ct[0];
        r_st[0] <= w_st; r_st[1] <= r_st[0];
        r_ca[0] <= w_ca; r_ca[1] <= r_ca[0];
        r_sa[0] <= w_sa; r_sa[1] <= r_sa[0];
    end

    assign o_valid           = r_vld[LAT-1];
    assign o_m00_cos_theta   = r_ct[1];
    assign o_m10_sin_theta   = r_st[1];
    assign o_m21_sin_alpha   = r_sa[1];
    assign o_m22_cos_alpha   = r_ca[1];
    assign o_m23_offset      = r_off[LAT-1];

    `DH_ASSERT_NEXT(a_no_busy, i_clk, i_rst_n, 1'b1, !busy)
    `DH_ASSERT_IMPL(a_trig_range, i_clk, i_rst_n, o_valid, (o_m00_cos_theta <= 18'sd65536) && (o_m00_cos_theta >= -18'sd65536))
    `DH_ASSERT_IMPL(a_off_align, i_clk, i_rst_n, o_valid, o_m23_offset == $past(i_link_offset, LAT))
endmodule

FILE: sim/dh_link_transform_unit_checker.sv
// Checker for the DH link transform unit: watches the start and result
// strobes, predicts each matrix from the link fields and compares entries.
// Depends only on the ports of dh_link_transform_unit.
`timescale 1ns / 1ps
module dh_link_transform_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [15:0]        i_joint_angle,
    input  logic [15:0]        i_twist_angle,
    input  logic signed [23:0] i_link_length,
    input  logic signed [23:0] i_link_offset,
    input  logic               o_valid,
    input  logic signed [17:0] o_m00_cos_theta,
    input  logic signed [17:0] o_m01_neg_sin_cos,
    input  logic signed [17:0] o_m02_sin_sin,
    input  logic signed [23:0] o_m03_len_cos,
    input  logic signed [17:0] o_m10_sin_theta,
    input  logic signed [17:0] o_m11_cos_cos,
    input  logic signed [17:0] o_m12_neg_cos_sin,
    input  logic signed [23:0] o_m13_len_sin,
    input  logic signed [17:0] o_m21_sin_alpha,
    input  logic signed [17:0] o_m22_cos_alpha,
    input  logic signed [23:0] o_m23_offset,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 <<< FRAC;

    typedef struct packed {
        logic signed [17:0] m00, m01, m02;
        logic signed [23:0] m03;
        logic signed [17:0] m10, m11, m12;
        logic signed [23:0] m13;
        logic signed [17:0] m21, m22;
        logic signed [23:0] m23;
    } t_matrix;

    t_matrix expected_matrices[$];
    int fails = 0;

    longint arc_step[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_down(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Rotate by the residual angle, then fix up the quadrant exactly.
    task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
        logic [31:0] p, diff;
        logic [1:0]  q;
        longint x, y, z, dx, dy, cr, sr;
        p = {ang, 16'h0};
        q = 2'((p + 32'h2000_0000) >> 30);
        diff = p - {q, 30'h0};
        z = longint'($signed(diff));
        x = 64'sh26DD3B6A;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_step[i];
            end else begin
                x += dx; y -= dy; z += arc_step[i];
            end
        end
        case (q)
            2'd0: begin cr = x;  sr = y;  end
            2'd1: begin cr = -y; sr = x;  end
            2'd2: begin cr = -x; sr = -y; end
            default: begin cr = y; sr = -x; end
        endcase
        c = clip(round_down(cr, 30 - FRAC), -ONE, ONE);
        s = clip(round_down(sr, 30 - FRAC), -ONE, ONE);
    endtask

    function automatic longint trig_product(longint a, longint b);
        return clip(round_down(a * b, FRAC), -ONE, ONE);
    endfunction

    function automatic longint length_product(longint r, longint t);
        return clip(round_down(r * t, FRAC), -64'sd8388608, 64'sd8388607);
    endfunction

    task automatic predict_link_matrix(input logic [15:0] th, input logic [15:0] al,
                                       input logic signed [23:0] r,
                                       input logic signed [23:0] d);
        longint ct, st, ca, sa;
        t_matrix m;
        sin_cos(th, ct, st);
        sin_cos(al, ca, sa);
        m.m00 = 18'(ct);
        m.m01 = 18'(-trig_product(st, ca));
        m.m02 = 18'(trig_product(st, sa));
        m.m03 = 24'(length_product(longint'(r), ct));
        m.m10 = 18'(st);
        m.m11 = 18'(trig_product(ct, ca));
        m.m12 = 18'(-trig_product(ct, sa));
        m.m13 = 24'(length_product(longint'(r), st));
        m.m21 = 18'(sa);
        m.m22 = 18'(ca);
        m.m23 = d;
        expected_matrices.push_back(m);
    endtask

    always @(posedge i_clk) begin
        t_matrix got, want;
        if (i_rst_n && start && !busy)
            predict_link_matrix(i_joint_angle, i_twist_angle, i_link_length, i_link_offset);
        if (i_rst_n && o_valid) begin
            got = '{o_m00_cos_theta, o_m01_neg_sin_cos, o_m02_sin_sin, o_m03_len_cos,
                    o_m10_sin_theta, o_m11_cos_cos, o_m12_neg_cos_sin, o_m13_len_sin,
                    o_m21_sin_alpha, o_m22_cos_alpha, o_m23_offset};
            if (expected_matrices.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected word: %h", got);
            end else begin
                want = expected_matrices.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: m00 %0d/%0d m01 %0d/%0d m02 %0d/%0d m03 %0d/%0d",
                                 want.m00, got.m00, want.m01, got.m01, want.m02,
                                 got.m02, want.m03, got.m03,
                                 "\n  m10 %0d/%0d m11 %0d/%0d m12 %0d/%0d m13 %0d/%0d",
                                 want.m10, got.m10, want.m11, got.m11, want.m12,
                                 got.m12, want.m13, got.m13,
                                 "\n  m21 %0d/%0d m22 %0d/%0d m23 %0d/%0d",
                                 want.m21, got.m21, want.m22, got.m22,
                                 want.m23, got.m23);
                end
            end
        end
    end

    assign o_fail_count = fails;
    assign o_pending    = expected_matrices.size();
endmodule

FILE: sim/dh_link_transform_unit_tb.sv
// Testbench top for the DH link transform unit: drives directed and random
// link words with random gaps; dh_link_transform_unit_checker does the checking.
`timescale 1ns / 1ps
module dh_link_transform_unit_tb;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [15:0]        i_joint_angle = '0;
    logic [15:0]        i_twist_angle = '0;
    logic signed [23:0] i_link_length = '0;
    logic signed [23:0] i_link_offset = '0;
    logic               o_valid;
    logic signed [17:0] o_m00_cos_theta, o_m01_neg_sin_cos, o_m02_sin_sin;
    logic signed [23:0] o_m03_len_cos;
    logic signed [17:0] o_m10_sin_theta, o_m11_cos_cos, o_m12_neg_cos_sin;
    logic signed [23:0] o_m13_len_sin;
    logic signed [17:0] o_m21_sin_alpha, o_m22_cos_alpha;
    logic signed [23:0] o_m23_offset;
    int                 fail_count, pending;

    // Directed angle corners: quarter turns, octant edges and wrap points.
    logic [15:0] corner_angles[12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
        16'h2000, 16'h1FFF, 16'h6000, 16'hA000, 16'hE000, 16'hFFFF, 16'h0001, 16'h5555};

    always #5 i_clk = ~i_clk;

    dh_link_transform_unit dut (.*);
    dh_link_transform_unit_checker checker_i (.*, .o_fail_count(fail_count),
                                              .o_pending(pending));

    // Drop start for the gap, then hold one word until the block takes it.
    task automatic send_word(input logic [15:0] th, input logic [15:0] al,
                             input logic [23:0] r, input logic [23:0] d, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_joint_angle <= th;
        i_twist_angle <= al;
        i_link_length <= r;
        i_link_offset <= d;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [23:0] pick_length();
        case ($urandom_range(0, 3))
            0: return 24'h7FFFFF - 24'($urandom_range(0, 3));
            1: return 24'h800000 + 24'($urandom_range(0, 3));
            2: return 24'($signed($urandom_range(0, 1024)) - 512);
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int gap;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Sweep the angle corners, pairing them with saturating lengths.
        for (int k = 0; k < 12; k++)
            send_word(corner_angles[k], corner_angles[11 - k],
                      k[0] ? 24'h7FFFFF : 24'h800000, k[1] ? 24'h800000 : 24'h7FFFFF, 0);
        send_word(16'h0000, 16'hFFFF, 24'h000000, 24'h000001, 1);
        send_word(16'h2000, 16'h6000, 24'hFFFFFF, 24'hFFFFFF, 2);
        for (int n = 0; n < 700; n++) begin
            // Bursts with no gap alternate with stretches of random gaps.
            gap = (n % 100 < 30) ? 0 : $urandom_range(0, 12);
            send_word($urandom_range(0, 7) == 0 ? corner_angles[$urandom_range(0, 11)]
                                                : 16'($urandom),
                      16'($urandom), pick_length(), 24'($urandom), gap);
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
